FILE: hw/rtl/sie_pkg.sv
// Shared types, opcode codes and flag layout for the instruction executor.
package sie_pkg;

  // Opcodes of the supported subset
  localparam logic [7:0] OpNop      = 8'h00;
  localparam logic [7:0] OpLdDeNn   = 8'h11;
  localparam logic [7:0] OpAddHlDe  = 8'h19;
  localparam logic [7:0] OpJrNz     = 8'h20;
  localparam logic [7:0] OpIncHl    = 8'h23;
  localparam logic [7:0] OpDecHl    = 8'h2B;
  localparam logic [7:0] OpJrNc     = 8'h30;
  localparam logic [7:0] OpLdHlN    = 8'h36;
  localparam logic [7:0] OpLdAN     = 8'h3E;
  localparam logic [7:0] OpLdBA     = 8'h47;
  localparam logic [7:0] OpLdHD     = 8'h62;
  localparam logic [7:0] OpLdLE     = 8'h6B;
  localparam logic [7:0] OpAndA     = 8'hA7;
  localparam logic [7:0] OpXorA     = 8'hAF;
  localparam logic [7:0] OpCpH      = 8'hBC;
  localparam logic [7:0] OpJpNz     = 8'hC2;
  localparam logic [7:0] OpJp       = 8'hC3;
  localparam logic [7:0] OpOutNA    = 8'hD3;
  localparam logic [7:0] OpPrefixEd = 8'hED;
  localparam logic [7:0] OpDi       = 8'hF3;

  // Sub-opcodes after the ED prefix
  localparam logic [7:0] EdLdIA     = 8'h47;
  localparam logic [7:0] EdSbcHlDe  = 8'h52;

  // Flag bit positions: S Z F5 H F3 PV N C
  localparam int unsigned FlagC  = 0;
  localparam int unsigned FlagN  = 1;
  localparam int unsigned FlagPv = 2;
  localparam int unsigned FlagH  = 4;
  localparam int unsigned FlagZ  = 6;
  localparam int unsigned FlagS  = 7;

  // Undocumented F3 and F5 bits survive every flag update
  localparam logic [7:0] FlagKeepMask = 8'h28;

  // Bus write kinds
  localparam logic [1:0] BusNone = 2'd0;
  localparam logic [1:0] BusMem  = 2'd1;
  localparam logic [1:0] BusIo   = 2'd2;

  // Status codes
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusUnknown = 1'b1;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  flags;
    logic [7:0]  reg_b;
    logic [7:0]  reg_c;
    logic [7:0]  reg_d;
    logic [7:0]  reg_e;
    logic [7:0]  reg_h;
    logic [7:0]  reg_l;
    logic [7:0]  int_page;
    logic [15:0] pc;
    logic        int_enable;
  } arch_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [1:0]  bus_kind;
    logic [15:0] bus_addr;
    logic [7:0]  bus_data;
    logic [7:0]  flags;
    logic [7:0]  acc;
    logic [15:0] hl;
    logic        status;
  } result_t;

endpackage

FILE: hw/rtl/sie_exec.sv
// Combinational execute of one instruction against the architectural state.
module sie_exec (
  input  sie_pkg::arch_t   cur_i,
  input  logic [7:0]       opcode_i,
  input  logic [7:0]       byte1_i,
  input  logic [7:0]       byte2_i,
  output sie_pkg::arch_t   nxt_o,
  output sie_pkg::result_t res_o
);

  logic [15:0] hl;
  logic [15:0] de;
  logic [15:0] nn;
  logic [15:0] pc_p1;
  logic [15:0] pc_p2;
  logic [15:0] pc_p3;
  logic [15:0] rel_pc;
  logic [16:0] add_sum;
  logic [16:0] sbc_diff;
  logic [8:0]  cp_diff;
  logic        cin;
  logic [7:0]  keep;
  logic [15:0] hl_new;
  logic [7:0]  f_new;
  logic [15:0] pc_new;
  logic [1:0]  kind;
  logic [15:0] baddr;
  logic [7:0]  bdata;
  logic        unknown;
  sie_pkg::arch_t nxt;

  assign hl     = {cur_i.reg_h, cur_i.reg_l};
  assign de     = {cur_i.reg_d, cur_i.reg_e};
  assign nn     = {byte2_i, byte1_i};
  assign pc_p1  = cur_i.pc + 16'd1;
  assign pc_p2  = cur_i.pc + 16'd2;
  assign pc_p3  = cur_i.pc + 16'd3;
  assign rel_pc = pc_p2 + {{8{byte1_i[7]}}, byte1_i};
  assign cin    = cur_i.flags[sie_pkg::FlagC];
  assign keep   = cur_i.flags & sie_pkg::FlagKeepMask;

  assign add_sum  = {1'b0, hl} + {1'b0, de};
  assign sbc_diff = {1'b0, hl} - {1'b0, de} - {16'd0, cin};
  assign cp_diff  = {1'b0, cur_i.acc} - {1'b0, cur_i.reg_h};

  always_comb begin
    nxt     = cur_i;
    hl_new  = hl;
    f_new   = cur_i.flags;
    pc_new  = pc_p1;
    kind    = sie_pkg::BusNone;
    baddr   = 16'd0;
    bdata   = 8'd0;
    unknown = 1'b0;

    unique case (opcode_i)
      sie_pkg::OpNop: begin
      end
      sie_pkg::OpLdDeNn: begin
        nxt.reg_d = byte2_i;
        nxt.reg_e = byte1_i;
        pc_new    = pc_p3;
      end
      sie_pkg::OpAddHlDe: begin
        hl_new = add_sum[15:0];
        f_new[sie_pkg::FlagN] = 1'b0;
        f_new[sie_pkg::FlagH] = hl[12] ^ de[12] ^ add_sum[12];
        f_new[sie_pkg::FlagC] = add_sum[16];
      end
      sie_pkg::OpJrNz: begin
        pc_new = cur_i.flags[sie_pkg::FlagZ] ? pc_p2 : rel_pc;
      end
      sie_pkg::OpIncHl: begin
        hl_new = hl + 16'd1;
      end
      sie_pkg::OpDecHl: begin
        hl_new = hl - 16'd1;
      end
      sie_pkg::OpJrNc: begin
        pc_new = cur_i.flags[sie_pkg::FlagC] ? pc_p2 : rel_pc;
      end
      sie_pkg::OpLdHlN: begin
        kind   = sie_pkg::BusMem;
        baddr  = hl;
        bdata  = byte1_i;
        pc_new = pc_p2;
      end
      sie_pkg::OpLdAN: begin
        nxt.acc = byte1_i;
        pc_new  = pc_p2;
      end
      sie_pkg::OpLdBA: begin
        nxt.reg_b = cur_i.acc;
      end
      sie_pkg::OpLdHD: begin
        hl_new = {cur_i.reg_d, hl[7:0]};
      end
      sie_pkg::OpLdLE: begin
        hl_new = {hl[15:8], cur_i.reg_e};
      end
      sie_pkg::OpAndA: begin
        f_new = keep;
        f_new[sie_pkg::FlagH]  = 1'b1;
        f_new[sie_pkg::FlagZ]  = (cur_i.acc == 8'd0);
        f_new[sie_pkg::FlagS]  = cur_i.acc[7];
        f_new[sie_pkg::FlagPv] = ~^cur_i.acc;
      end
      sie_pkg::OpXorA: begin
        nxt.acc = 8'd0;
        f_new = keep;
        f_new[sie_pkg::FlagZ]  = 1'b1;
        f_new[sie_pkg::FlagPv] = 1'b1;
      end
      sie_pkg::OpCpH: begin
        f_new = keep;
        f_new[sie_pkg::FlagN]  = 1'b1;
        f_new[sie_pkg::FlagS]  = cp_diff[7];
        f_new[sie_pkg::FlagZ]  = (cp_diff[7:0] == 8'd0);
        f_new[sie_pkg::FlagH]  = cur_i.acc[4] ^ cur_i.reg_h[4] ^ cp_diff[4];
        f_new[sie_pkg::FlagPv] = (cur_i.acc[7] ^ cur_i.reg_h[7])
                               & (cur_i.acc[7] ^ cp_diff[7]);
        f_new[sie_pkg::FlagC]  = cp_diff[8];
      end
      sie_pkg::OpJpNz: begin
        pc_new = cur_i.flags[sie_pkg::FlagZ] ? pc_p3 : nn;
      end
      sie_pkg::OpJp: begin
        pc_new = nn;
      end
      sie_pkg::OpOutNA: begin
        kind   = sie_pkg::BusIo;
        baddr  = {cur_i.acc, byte1_i};
        bdata  = cur_i.acc;
        pc_new = pc_p2;
      end
      sie_pkg::OpPrefixEd: begin
        unique case (byte1_i)
          sie_pkg::EdLdIA: begin
            nxt.int_page = cur_i.acc;
            pc_new       = pc_p2;
          end
          sie_pkg::EdSbcHlDe: begin
            hl_new = sbc_diff[15:0];
            f_new  = keep;
            f_new[sie_pkg::FlagN]  = 1'b1;
            f_new[sie_pkg::FlagS]  = sbc_diff[15];
            f_new[sie_pkg::FlagZ]  = (sbc_diff[15:0] == 16'd0);
            f_new[sie_pkg::FlagH]  = hl[12] ^ de[12] ^ sbc_diff[12];
            f_new[sie_pkg::FlagPv] = (hl[15] ^ de[15]) & (hl[15] ^ sbc_diff[15]);
            f_new[sie_pkg::FlagC]  = sbc_diff[16];
            pc_new = pc_p2;
          end
          default: begin
            unknown = 1'b1;
          end
        endcase
      end
      sie_pkg::OpDi: begin
        nxt.int_enable = 1'b0;
      end
      default: begin
        unknown = 1'b1;
      end
    endcase

    if (unknown) begin
      // drop every effect; bus fields are already zero
      nxt = cur_i;
    end else begin
      nxt.flags = f_new;
      nxt.reg_h = hl_new[15:8];
      nxt.reg_l = hl_new[7:0];
      nxt.pc    = pc_new;
    end
  end

  assign nxt_o = nxt;

  assign res_o.next_pc  = nxt.pc;
  assign res_o.bus_kind = kind;
  assign res_o.bus_addr = baddr;
  assign res_o.bus_data = bdata;
  assign res_o.flags    = nxt.flags;
  assign res_o.acc      = nxt.acc;
  assign res_o.hl       = {nxt.reg_h, nxt.reg_l};
  assign res_o.status   = unknown ? sie_pkg::StatusUnknown : sie_pkg::StatusOk;

endmodule

FILE: hw/rtl/sie_state.sv
// Architectural register file, cleared by reset and updated on each executed transfer.
module sie_state (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           commit_i,
  input  sie_pkg::arch_t state_d_i,
  output sie_pkg::arch_t state_q_o
);

  sie_pkg::arch_t state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (commit_i) begin
      state_q <= state_d_i;
    end
  end

  assign state_q_o = state_q;

endmodule

FILE: hw/rtl/z80_subset_instruction_executor.sv
// Top level of the subset instruction executor: input register, execute, result register.
//
// One instruction (opcode plus the two bytes that follow it) is taken per transfer and
// one result comes back for it. The block sustains one instruction per clock cycle while
// the result side does not stall. The bytes land in an input register on the input
// transfer; the combinational execute pass then runs on them against the register file
// and loads the result register once it is free or draining. The loop through the
// register file (PC, flags, HL and the rest) closes within that execute pass, so each
// instruction sees the state left by the one before it. Unknown opcodes, including any ED
// sub-opcode other than LD I,A and SBC HL,DE, return status 1 with the PC and all
// registers unchanged. Stall on the result side holds the result register; the input
// register then holds one further instruction before in_stall_o rises.
module z80_subset_instruction_executor (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  opcode_byte_i,
  input  logic [7:0]  second_byte_i,
  input  logic [7:0]  third_byte_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] next_pc_o,
  output logic [1:0]  bus_kind_o,
  output logic [15:0] bus_addr_o,
  output logic [7:0]  bus_data_o,
  output logic [7:0]  flags_out_o,
  output logic [7:0]  acc_out_o,
  output logic [15:0] hl_out_o,
  output logic        status_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] op_q;
  logic [7:0] b1_q;
  logic [7:0] b2_q;

  // result register
  logic             out_valid_q;
  sie_pkg::result_t res_q;

  sie_pkg::arch_t   state_q;
  sie_pkg::arch_t   state_d;
  sie_pkg::result_t res_d;

  logic exec_go;
  logic in_xfer;
  logic out_xfer;

  // Execute when an instruction waits and the result register is free or draining.
  assign exec_go    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~exec_go;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_xfer   = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (exec_go) begin
      in_valid_q <= 1'b0;
    end
  end

  // Capture instruction bytes on an input transfer; hold them otherwise.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q <= opcode_byte_i;
      b1_q <= second_byte_i;
      b2_q <= third_byte_i;
    end
  end

  sie_exec u_exec (
    .cur_i    (state_q),
    .opcode_i (op_q),
    .byte1_i  (b1_q),
    .byte2_i  (b2_q),
    .nxt_o    (state_d),
    .res_o    (res_d)
  );

  // Advance the register file together with the result register.
  sie_state u_state (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .commit_i  (exec_go),
    .state_d_i (state_d),
    .state_q_o (state_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_go) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign next_pc_o   = res_q.next_pc;
  assign bus_kind_o  = res_q.bus_kind;
  assign bus_addr_o  = res_q.bus_addr;
  assign bus_data_o  = res_q.bus_data;
  assign flags_out_o = res_q.flags;
  assign acc_out_o   = res_q.acc;
  assign hl_out_o    = res_q.hl;
  assign status_o    = res_q.status;

endmodule
